// File: design/abrf_pkg.sv
// ----------------------------------------------------------------------------
// abrf_pkg
// Types, constants and helper functions for the banked register file.
// ----------------------------------------------------------------------------
package abrf_pkg;

  // operation codes on the command beat
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SWITCH = 3'd2,
    OP_IRQ    = 3'd3,
    OP_COND   = 3'd4,
    OP_STATUS = 3'd5,
    OP_SPSR   = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
    COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
    COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
    COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
  } cond_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SW_RD_VIS,
    ST_SW_RD_BANK,
    ST_SW_WR_BANK,
    ST_SW_WR_VIS,
    ST_IRQ_RD_PC,
    ST_IRQ_WR_LR,
    ST_IRQ_WR_PC
  } state_e;

  // processor mode encodings
  localparam logic [4:0] PMODE_USER   = 5'h10;
  localparam logic [4:0] PMODE_FAST   = 5'h11;
  localparam logic [4:0] PMODE_INTR   = 5'h12;
  localparam logic [4:0] PMODE_SUPV   = 5'h13;
  localparam logic [4:0] PMODE_ABORT  = 5'h17;
  localparam logic [4:0] PMODE_UNDEF  = 5'h1B;
  localparam logic [4:0] PMODE_SYSTEM = 5'h1F;

  localparam logic [2:0] BNK_SHARED = 3'd0;
  localparam logic [2:0] BNK_FAST   = 3'd1;
  localparam logic [2:0] BNK_INTR   = 3'd2;
  localparam logic [2:0] BNK_SUPV   = 3'd3;
  localparam logic [2:0] BNK_ABORT  = 3'd4;
  localparam logic [2:0] BNK_UNDEF  = 3'd5;

  localparam int NUM_BANKS  = 6;
  localparam int BANK_WORDS = 7;
  localparam int NUM_VIS    = 16;
  localparam int RAM_DEPTH  = NUM_VIS + NUM_BANKS * BANK_WORDS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);

  localparam logic [2:0] WORD_R8   = 3'd0;  // r8 slot within a bank
  localparam logic [2:0] WORD_SP   = 3'd5;  // r13 slot within a bank
  localparam logic [2:0] WORD_LAST = 3'd6;  // r14 slot within a bank

  localparam logic [3:0] REG_BANK_LO = 4'd8;
  localparam logic [3:0] REG_SP      = 4'd13;
  localparam logic [3:0] REG_LR      = 4'd14;
  localparam logic [3:0] REG_PC      = 4'd15;

  localparam logic [31:0] IRQ_VECTOR = 32'h18;
  localparam logic [31:0] PC_AHEAD   = 32'h8;
  localparam logic [31:0] LR_ADJUST  = 32'h4;
  localparam logic [31:0] CPSR_RESET = {27'd0, PMODE_SYSTEM};

  localparam int FLAG_LSB = 28;
  localparam int BIT_I    = 7;
  localparam int BIT_T    = 5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  reg_index;
    logic [31:0] value;
    logic [4:0]  new_mode;
    logic [3:0]  cond;
  } abrf_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        cond_pass;
    logic        irq_taken;
    logic        bad_mode;
    logic [31:0] status_word;
  } abrf_out_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  bank;
  } mode_info_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [31:0] cpsr;
    logic [31:0] spsr_cur;
    logic [31:0] exc_base;
  } psr_stat_t;

  typedef struct packed {
    logic        cpsr_we;
    logic [31:0] cpsr_d;
    logic        spsr_we;
    logic [2:0]  spsr_idx;
    logic [31:0] spsr_d;
  } psr_upd_t;

  function automatic mode_info_t bank_of(logic [4:0] m);
    mode_info_t r;
    r.ok = 1'b1;
    case (m)
      PMODE_USER, PMODE_SYSTEM: r.bank = BNK_SHARED;
      PMODE_FAST:               r.bank = BNK_FAST;
      PMODE_INTR:               r.bank = BNK_INTR;
      PMODE_SUPV:               r.bank = BNK_SUPV;
      PMODE_ABORT:              r.bank = BNK_ABORT;
      PMODE_UNDEF:              r.bank = BNK_UNDEF;
      default: begin
        r.ok   = 1'b0;
        r.bank = BNK_SHARED;
      end
    endcase
    return r;
  endfunction

  // memory address of slot w of bank b; visible registers sit below
  function automatic logic [RAM_AW-1:0] bank_addr(logic [2:0] b, logic [2:0] w);
    return RAM_AW'(NUM_VIS + int'(b) * BANK_WORDS + int'(w));
  endfunction

  function automatic logic [RAM_AW-1:0] vis_addr(logic [3:0] r);
    return RAM_AW'(r);
  endfunction

  function automatic logic cond_holds(logic [3:0] c, logic [3:0] f);
    logic n, z, cf, v, r;
    n  = f[3];
    z  = f[2];
    cf = f[1];
    v  = f[0];
    case (c)
      COND_EQ: r = z;
      COND_NE: r = !z;
      COND_CS: r = cf;
      COND_CC: r = !cf;
      COND_MI: r = n;
      COND_PL: r = !n;
      COND_VS: r = v;
      COND_VC: r = !v;
      COND_HI: r = cf && !z;
      COND_LS: r = !cf || z;
      COND_GE: r = (n == v);
      COND_LT: r = (n != v);
      COND_GT: r = !(z || (n != v));
      COND_LE: r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: design/arm_banked_register_file.sv
// ----------------------------------------------------------------------------
// arm_banked_register_file
// ARM register file: r0-r15, banked r8-r14 for six banks, SPSRs and CPSR,
// with mode switch, status write and IRQ entry.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+-------------------------------
//  command  | start, busy, cmd_i               | start && !busy
//  result   | done_o, res_o                    | one-cycle strobe on done_o
//  config   | cfg_we_i, cfg_wdata_i            | cfg_we_i, exception base
//
//  busy stays high after a command beat until it ends. Write, condition,
//  SPSR read, switch within a bank, masked IRQ and bad mode end in EXEC;
//  reads add RD_WAIT; swaps move r13-r14 or FIQ r8-r14; IRQ entry sets LR, PC.
//  Each swapped word takes four steps on the one-read, one-write register RAM.
//  The result strobe comes in the cycle busy falls; results cannot stall.
//  Reset needs no clearing pass: per-entry valid bits make the RAM read zero.
// ----------------------------------------------------------------------------
module arm_banked_register_file (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  abrf_pkg::abrf_in_t  cmd_i,
  output logic                done_o,
  output abrf_pkg::abrf_out_t res_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import abrf_pkg::*;

  ram_req_t    ram_req;
  logic [31:0] ram_rdata;
  logic [31:0] rdata_masked;
  psr_stat_t   psr_stat;
  psr_upd_t    psr_upd;

  logic [RAM_DEPTH-1:0] vld_q;
  logic                 rvld_q;

  abrf_ram #(
    .Width (32),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ram_req.we) begin
        vld_q[ram_req.waddr] <= 1'b1;
      end
      if (ram_req.re) begin
        rvld_q <= vld_q[ram_req.raddr];
      end
    end
  end

  assign rdata_masked = rvld_q ? ram_rdata : '0;

  abrf_psr u_psr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (psr_upd),
    .stat_o      (psr_stat)
  );

  abrf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (rdata_masked),
    .psr_i       (psr_stat),
    .psr_upd_o   (psr_upd),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// File: design/abrf_ram.sv
// ----------------------------------------------------------------------------
// abrf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module abrf_ram #(
  parameter int Width = 32,
  parameter int Depth = 58
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/abrf_psr.sv
// ----------------------------------------------------------------------------
// abrf_psr
// CPSR, per-bank SPSRs and the exception base register.
// ----------------------------------------------------------------------------
module abrf_psr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  abrf_pkg::psr_upd_t  upd_i,
  output abrf_pkg::psr_stat_t stat_o
);
  import abrf_pkg::*;

  logic [31:0] cpsr_q;
  logic [31:0] spsr_q [NUM_BANKS];
  logic [31:0] base_q;
  mode_info_t  cur_info;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpsr_q <= CPSR_RESET;
      base_q <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        spsr_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (upd_i.cpsr_we) begin
        cpsr_q <= upd_i.cpsr_d;
      end
      if (upd_i.spsr_we) begin
        spsr_q[upd_i.spsr_idx] <= upd_i.spsr_d;
      end
    end
  end

  always_comb begin
    cur_info        = bank_of(cpsr_q[4:0]);
    stat_o.cpsr     = cpsr_q;
    stat_o.exc_base = base_q;
    // user and system modes read the unbanked SPSR
    stat_o.spsr_cur = cur_info.ok ? spsr_q[cur_info.bank] : spsr_q[BNK_SHARED];
  end

endmodule

// File: design/abrf_seq.sv
// ----------------------------------------------------------------------------
// abrf_seq
// Command sequencer: decodes a beat, drives the register RAM through
// read-modify-write steps for bank swaps and IRQ entry, updates the PSRs.
// ----------------------------------------------------------------------------
module abrf_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  abrf_pkg::abrf_in_t  cmd_i,
  output abrf_pkg::ram_req_t  ram_req_o,
  input  logic [31:0]         ram_rdata_i,
  input  abrf_pkg::psr_stat_t psr_i,
  output abrf_pkg::psr_upd_t  psr_upd_o,
  output logic                done_o,
  output abrf_pkg::abrf_out_t res_o
);
  import abrf_pkg::*;

  state_e      state_q, state_d;
  abrf_in_t    cmd_q, cmd_d;
  logic [2:0]  from_q, from_d;
  logic [2:0]  to_q, to_d;
  logic [2:0]  word_q, word_d;
  logic        irq_q, irq_d;
  logic        thumb_q, thumb_d;
  logic [31:0] tmp_q, tmp_d;
  logic        done_q, done_d;
  logic [31:0] rd_q, rd_d;
  logic        pass_q, pass_d;
  logic        taken_q, taken_d;
  logic        bad_q, bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    from_q  <= from_d;
    to_q    <= to_d;
    word_q  <= word_d;
    irq_q   <= irq_d;
    thumb_q <= thumb_d;
    tmp_q   <= tmp_d;
    rd_q    <= rd_d;
    pass_q  <= pass_d;
    taken_q <= taken_d;
    bad_q   <= bad_d;
  end

  always_comb begin
    mode_info_t cur_info;
    mode_info_t tgt_info;
    logic [2:0] from_b;

    cur_info = bank_of(psr_i.cpsr[4:0]);
    from_b   = cur_info.ok ? cur_info.bank : BNK_SHARED;
    tgt_info = '0;

    state_d = state_q;
    cmd_d   = cmd_q;
    from_d  = from_q;
    to_d    = to_q;
    word_d  = word_q;
    irq_d   = irq_q;
    thumb_d = thumb_q;
    tmp_d   = tmp_q;
    done_d  = 1'b0;
    rd_d    = '0;
    pass_d  = 1'b0;
    taken_d = 1'b0;
    bad_d   = 1'b0;
    ram_req_o = '0;
    psr_upd_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        case (cmd_q.mode)
          OP_READ: begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = vis_addr(cmd_q.reg_index);
            done_d          = 1'b0;
            state_d         = ST_RD_WAIT;
          end
          OP_WRITE: begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = vis_addr(cmd_q.reg_index);
            ram_req_o.wdata = cmd_q.value;
          end
          OP_SWITCH, OP_STATUS: begin
            tgt_info = (cmd_q.mode == OP_SWITCH) ? bank_of(cmd_q.new_mode)
                                                  : bank_of(cmd_q.value[4:0]);
            if (!tgt_info.ok) begin
              bad_d = 1'b1;
            end else begin
              psr_upd_o.cpsr_we = 1'b1;
              psr_upd_o.cpsr_d  = (cmd_q.mode == OP_SWITCH) ?
                                  {psr_i.cpsr[31:5], cmd_q.new_mode} : cmd_q.value;
              if (tgt_info.bank != from_b) begin
                from_d  = from_b;
                to_d    = tgt_info.bank;
                // FIQ swaps r8-r14, other banks r13-r14 only
                word_d  = (from_b == BNK_FAST || tgt_info.bank == BNK_FAST) ?
                          WORD_R8 : WORD_SP;
                irq_d   = 1'b0;
                done_d  = 1'b0;
                state_d = ST_SW_RD_VIS;
              end
            end
          end
          OP_IRQ: begin
            if (!psr_i.cpsr[BIT_I]) begin
              psr_upd_o.spsr_we  = 1'b1;
              psr_upd_o.spsr_idx = BNK_INTR;
              psr_upd_o.spsr_d   = psr_i.cpsr;
              psr_upd_o.cpsr_we  = 1'b1;
              psr_upd_o.cpsr_d   = {psr_i.cpsr[31:8], 1'b1, psr_i.cpsr[6], 1'b0,
                                    PMODE_INTR};
              thumb_d = psr_i.cpsr[BIT_T];
              done_d  = 1'b0;
              if (from_b != BNK_INTR) begin
                from_d  = from_b;
                to_d    = BNK_INTR;
                word_d  = (from_b == BNK_FAST) ? WORD_R8 : WORD_SP;
                irq_d   = 1'b1;
                state_d = ST_SW_RD_VIS;
              end else begin
                state_d = ST_IRQ_RD_PC;
              end
            end
          end
          OP_COND: begin
            pass_d = cond_holds(cmd_q.cond, psr_i.cpsr[FLAG_LSB +: 4]);
          end
          OP_SPSR: begin
            rd_d = psr_i.spsr_cur;
          end
          default: begin
          end
        endcase
      end

      ST_RD_WAIT: begin
        rd_d    = ram_rdata_i;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SW_RD_VIS: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = vis_addr(REG_BANK_LO + {1'b0, word_q});
        state_d         = ST_SW_RD_BANK;
      end

      ST_SW_RD_BANK: begin
        tmp_d           = ram_rdata_i;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = bank_addr(to_q, word_q);
        state_d         = ST_SW_WR_BANK;
      end

      ST_SW_WR_BANK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = bank_addr(from_q, word_q);
        ram_req_o.wdata = tmp_q;
        tmp_d           = ram_rdata_i;
        state_d         = ST_SW_WR_VIS;
      end

      ST_SW_WR_VIS: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = vis_addr(REG_BANK_LO + {1'b0, word_q});
        ram_req_o.wdata = tmp_q;
        if (word_q != WORD_LAST) begin
          word_d  = word_q + 3'd1;
          state_d = ST_SW_RD_VIS;
        end else if (irq_q) begin
          state_d = ST_IRQ_RD_PC;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_IRQ_RD_PC: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = vis_addr(REG_PC);
        state_d         = ST_IRQ_WR_LR;
      end

      ST_IRQ_WR_LR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = vis_addr(REG_LR);
        ram_req_o.wdata = thumb_q ? ram_rdata_i : ram_rdata_i - LR_ADJUST;
        state_d         = ST_IRQ_WR_PC;
      end

      ST_IRQ_WR_PC: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = vis_addr(REG_PC);
        ram_req_o.wdata = psr_i.exc_base + IRQ_VECTOR + PC_AHEAD;
        taken_d         = 1'b1;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  // CPSR is settled by the strobe cycle and cannot move before it ends
  always_comb begin
    res_o.read_data   = rd_q;
    res_o.cond_pass   = pass_q;
    res_o.irq_taken   = taken_q;
    res_o.bad_mode    = bad_q;
    res_o.status_word = psr_i.cpsr;
  end

endmodule

// File: design/abrf_checker.sv
// ----------------------------------------------------------------------------
// abrf_checker
// Port-level checks on the banked register file, bound to the top level.
// ----------------------------------------------------------------------------
module abrf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_i,
  input logic                done_i,
  input abrf_pkg::abrf_out_t res_i
);
  import abrf_pkg::*;

  // every accepted command beat raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("command beat not followed by busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("busy fell without a result beat");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe longer than one cycle");

  a_irq_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && res_i.irq_taken |-> res_i.status_word[4:0] == PMODE_INTR &&
      res_i.status_word[BIT_I] && !res_i.status_word[BIT_T])
    else $error("IRQ taken but CPSR not in IRQ state");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && res_i.bad_mode |-> res_i.read_data == '0 && !res_i.irq_taken &&
      !res_i.cond_pass)
    else $error("bad mode result carries other fields");

endmodule

bind arm_banked_register_file abrf_checker u_abrf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o),
  .res_i   (res_o)
);

// File: tb/arm_banked_register_file_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_banked_register_file_test
// Self-checking bench for the banked register file. A queue of commands
// feeds a bursty driver; every command beat runs through an in-bench copy
// of the register file, CPSR and SPSRs, and the monitor compares each
// result strobe field by field with the oldest prediction. The vector
// base is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module arm_banked_register_file_test;
  import abrf_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat of any kind
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 400;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  abrf_in_t    cmd         = '0;
  logic        done_o;
  abrf_out_t   res_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  arm_banked_register_file dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // register file copy
  // ---------------------------------------------------------------------------
  logic [31:0] vec_base;
  logic [31:0] gpr     [NUM_VIS];
  logic [31:0] bank_mem[NUM_BANKS * BANK_WORDS];
  logic [31:0] spsr_mem[NUM_BANKS];
  logic [31:0] cpsr;

  logic [4:0] valid_modes[7] = '{PMODE_USER, PMODE_FAST, PMODE_INTR, PMODE_SUPV,
                                 PMODE_ABORT, PMODE_UNDEF, PMODE_SYSTEM};

  abrf_in_t  cmd_queue[$];
  abrf_out_t result_queue[$];

  int mismatches   = 0;
  int cmds_sent    = 0;
  int results_seen = 0;
  int irqs_taken   = 0;
  int bad_modes    = 0;
  int base_changes = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int idle_cycles  = 0;

  task automatic clear_regfile();
    vec_base = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (bank_mem[i]) bank_mem[i] = '0;
    foreach (spsr_mem[i]) spsr_mem[i] = '0;
    cpsr = CPSR_RESET;
    gpr[REG_PC] = vec_base;
  endtask

  // bank number of a mode encoding, -1 when not a legal mode
  function automatic int mode_bank(logic [4:0] m);
    case (m)
      PMODE_USER, PMODE_SYSTEM: return int'(BNK_SHARED);
      PMODE_FAST:               return int'(BNK_FAST);
      PMODE_INTR:               return int'(BNK_INTR);
      PMODE_SUPV:               return int'(BNK_SUPV);
      PMODE_ABORT:              return int'(BNK_ABORT);
      PMODE_UNDEF:              return int'(BNK_UNDEF);
      default:                  return -1;
    endcase
  endfunction

  // target must be a legal mode
  function automatic void enter_mode(logic [4:0] target);
    int from;
    int to;
    from = mode_bank(cpsr[4:0]);
    to   = mode_bank(target);
    if (from < 0) from = 0;
    cpsr[4:0] = target;
    if (from == to) return;
    if (from == int'(BNK_FAST) || to == int'(BNK_FAST)) begin
      for (int i = 0; i < BANK_WORDS; i++)
        bank_mem[from * BANK_WORDS + i] = gpr[int'(REG_BANK_LO) + i];
      for (int i = 0; i < BANK_WORDS; i++)
        gpr[int'(REG_BANK_LO) + i] = bank_mem[to * BANK_WORDS + i];
    end else begin
      bank_mem[from * BANK_WORDS + int'(WORD_SP)]   = gpr[REG_SP];
      bank_mem[from * BANK_WORDS + int'(WORD_LAST)] = gpr[REG_LR];
      gpr[REG_SP] = bank_mem[to * BANK_WORDS + int'(WORD_SP)];
      gpr[REG_LR] = bank_mem[to * BANK_WORDS + int'(WORD_LAST)];
    end
  endfunction

  function automatic logic flags_pass(logic [3:0] c, logic [3:0] f);
    logic n;
    logic z;
    logic cf;
    logic v;
    n  = f[3];
    z  = f[2];
    cf = f[1];
    v  = f[0];
    case (cond_e'(c))
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return cf;
      COND_CC: return !cf;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return cf && !z;
      COND_LS: return !cf || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  // applies one command to the copy and returns the result it should produce
  function automatic abrf_out_t exec_command(abrf_in_t c);
    abrf_out_t r;
    int        b;
    r = '0;
    case (op_e'(c.mode))
      OP_READ:  r.read_data = gpr[c.reg_index];
      OP_WRITE: gpr[c.reg_index] = c.value;
      OP_SWITCH: begin
        if (mode_bank(c.new_mode) < 0) r.bad_mode = 1'b1;
        else enter_mode(c.new_mode);
      end
      OP_IRQ: begin
        if (!cpsr[BIT_I]) begin
          spsr_mem[BNK_INTR] = cpsr;
          enter_mode(PMODE_INTR);
          cpsr[BIT_I] = 1'b1;
          if (cpsr[BIT_T]) begin
            cpsr[BIT_T] = 1'b0;
            gpr[REG_LR] = gpr[REG_PC];
          end else begin
            gpr[REG_LR] = gpr[REG_PC] - LR_ADJUST;
          end
          gpr[REG_PC] = vec_base + IRQ_VECTOR + PC_AHEAD;
          r.irq_taken = 1'b1;
        end
      end
      OP_COND: r.cond_pass = flags_pass(c.cond, cpsr[FLAG_LSB +: 4]);
      OP_STATUS: begin
        if (mode_bank(c.value[4:0]) < 0) begin
          r.bad_mode = 1'b1;
        end else begin
          enter_mode(c.value[4:0]);
          cpsr = c.value;
        end
      end
      OP_SPSR: begin
        b = mode_bank(cpsr[4:0]);
        if (b < 0) b = 0;
        r.read_data = spsr_mem[b];
      end
      default: ;
    endcase
    r.status_word = cpsr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic abrf_in_t make_cmd(op_e op, logic [3:0] idx, logic [31:0] val,
                                        logic [4:0] nm, logic [3:0] cc);
    abrf_in_t c;
    c.mode      = op;
    c.reg_index = idx;
    c.value     = val;
    c.new_mode  = nm;
    c.cond      = cc;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic abrf_in_t rand_cmd();
    abrf_in_t c;
    int       pick;
    c.reg_index = 4'($urandom_range(0, 15));
    c.value     = rand_word();
    c.new_mode  = 5'($urandom_range(0, 31));
    c.cond      = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c.mode = OP_READ;
    end else if (pick < 40) begin
      c.mode = OP_WRITE;
    end else if (pick < 55) begin
      c.mode = OP_SWITCH;
      if ($urandom_range(0, 4) != 0) c.new_mode = valid_modes[$urandom_range(0, 6)];
    end else if (pick < 65) begin
      c.mode = OP_IRQ;
    end else if (pick < 78) begin
      c.mode = OP_COND;
    end else if (pick < 90) begin
      // mostly legal modes, I clear half the time so IRQs keep getting in
      c.mode = OP_STATUS;
      if ($urandom_range(0, 4) != 0) c.value[4:0] = valid_modes[$urandom_range(0, 6)];
      if ($urandom_range(0, 1) != 0) c.value[BIT_I] = 1'b0;
    end else begin
      c.mode = OP_SPSR;
    end
    return c;
  endfunction

  task automatic load_directed();
    cmd_queue.push_back(make_cmd(OP_READ,   REG_PC, '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_READ,   4'd0,  '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_WRITE,  4'd0,  32'hFFFF_FFFF, '0, '0));
    cmd_queue.push_back(make_cmd(OP_READ,   4'd0,  '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_SWITCH, '0, '0, 5'h00, '0));          // illegal mode
    cmd_queue.push_back(make_cmd(OP_SWITCH, '0, '0, PMODE_FAST, '0));     // full r8-r14 swap
    cmd_queue.push_back(make_cmd(OP_WRITE,  REG_BANK_LO, 32'hA5A5_A5A5, '0, '0));
    cmd_queue.push_back(make_cmd(OP_WRITE,  REG_LR, 32'h1234_5678, '0, '0));
    cmd_queue.push_back(make_cmd(OP_SWITCH, '0, '0, PMODE_SUPV, '0));
    cmd_queue.push_back(make_cmd(OP_READ,   REG_BANK_LO, '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_SWITCH, '0, '0, PMODE_FAST, '0));
    cmd_queue.push_back(make_cmd(OP_READ,   REG_BANK_LO, '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_STATUS, '0, 32'h6000_0013, '0, '0)); // Z C set, SVC
    cmd_queue.push_back(make_cmd(OP_COND,   '0, '0, '0, COND_HI));
    cmd_queue.push_back(make_cmd(OP_COND,   '0, '0, '0, COND_LS));
    cmd_queue.push_back(make_cmd(OP_COND,   '0, '0, '0, COND_NV));
    cmd_queue.push_back(make_cmd(OP_WRITE,  REG_PC, 32'h0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_IRQ,    '0, '0, '0, '0));             // lr wraps below zero
    cmd_queue.push_back(make_cmd(OP_IRQ,    '0, '0, '0, '0));             // masked now
    cmd_queue.push_back(make_cmd(OP_SPSR,   '0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(OP_STATUS, '0, 32'h0000_003F, '0, '0)); // SYS, Thumb, I clear
    cmd_queue.push_back(make_cmd(OP_IRQ,    '0, '0, '0, '0));             // Thumb entry
    cmd_queue.push_back(make_cmd(OP_STATUS, '0, 32'hFFFF_FFE1, '0, '0)); // illegal mode bits
    cmd_queue.push_back(make_cmd(OP_SWITCH, '0, '0, PMODE_USER, '0));
    cmd_queue.push_back(make_cmd(OP_SPSR,   '0, '0, '0, '0));             // user mode SPSR
    cmd_queue.push_back(make_cmd(OP_READ,   REG_LR, '0, '0, '0));
  endtask

  task automatic load_random(int n);
    for (int i = 0; i < n; i++) cmd_queue.push_back(rand_cmd());
  endtask

  // returns at a falling edge with nothing queued, in flight or outstanding
  task automatic drain();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start || busy || result_queue.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_vec_base(logic [31:0] b);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vec_base = b;
    base_changes++;
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %08h want %08h", results_seen, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of command beats with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        result_queue.push_back(exec_command(cmd));
        cmds_sent++;
      end
      // a command still waiting on busy stays on the port untouched
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
          cmd   <= cmd_queue.pop_front();
          start <= 1'b1;
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 15);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    abrf_out_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected beat status_word", res_o.status_word, '0);
      end else begin
        want = result_queue.pop_front();
        if (res_o.read_data !== want.read_data)
          report_mismatch("read_data", res_o.read_data, want.read_data);
        if (res_o.cond_pass !== want.cond_pass)
          report_mismatch("cond_pass", 32'(res_o.cond_pass), 32'(want.cond_pass));
        if (res_o.irq_taken !== want.irq_taken)
          report_mismatch("irq_taken", 32'(res_o.irq_taken), 32'(want.irq_taken));
        if (res_o.bad_mode !== want.bad_mode)
          report_mismatch("bad_mode", 32'(res_o.bad_mode), 32'(want.bad_mode));
        if (res_o.status_word !== want.status_word)
          report_mismatch("status_word", res_o.status_word, want.status_word);
        if (want.irq_taken) irqs_taken++;
        if (want.bad_mode) bad_modes++;
      end
    end
  end

  // watchdog on cycles with neither a command beat nor a result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] bases[5];
    bases = '{32'hFFFF_FFFF, 32'hFFFF_FFE0, $urandom, 32'h8000_0000, 32'h0000_0000};
    clear_regfile();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    load_directed();
    drain();
    foreach (bases[i]) begin
      set_vec_base(bases[i]);
      load_random(PHASE_ITEMS);
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_queue.size() != 0) begin
      $display("%0d results never arrived", result_queue.size());
      mismatches++;
    end
    $display("ran %0d commands, %0d results, over %0d vector base settings",
             cmds_sent, results_seen, base_changes + 1);
    $display("saw %0d IRQ entries and %0d illegal mode requests", irqs_taken, bad_modes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
